### hw/rtl/bbl_pkg.sv
// bbl_pkg: shared constants, types and helper functions for the box blur line filter
// depends on nothing; imported by every module of the block

package bbl_pkg;

    localparam int MAX_RADIUS   = 31;
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_LINE     = 4096;

    localparam int PIX_W       = 8;
    localparam int RAD_W       = 5;
    localparam int CH_W        = 3;
    localparam int LEN_W       = 13;
    localparam int POS_W       = 12;
    localparam int SUM_W       = 14;
    localparam int CNT_W       = 6;
    localparam int DELAY_DEPTH = 64;
    localparam int DELAY_AW    = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int STEP_W      = 3;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [1:0] REG_RADIUS   = 2'd0;
    localparam logic [1:0] REG_CHANNELS = 2'd1;
    localparam logic [1:0] REG_LENGTH   = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RST   = 5'd1;
    localparam logic [CH_W-1:0]  CHANNELS_RST = 3'd3;
    localparam logic [LEN_W-1:0] LENGTH_RST   = 13'd640;

    typedef struct packed {
        logic [RAD_W-1:0] radius;
        logic [CH_W-1:0]  channels;
        logic [LEN_W-1:0] length;
    } cfg_t;

    typedef struct packed {
        logic [MAX_CHANNELS*PIX_W-1:0] pix;
        logic [POS_W-1:0]              pos;
        logic                          drop;
        logic                          emit;
        logic                          last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef logic [MAX_CHANNELS-1:0][SUM_W-1:0] sum_arr_t;
    typedef logic [MAX_CHANNELS-1:0][PIX_W-1:0] mean_arr_t;

    function automatic logic [CH_W-1:0] eff_channels(input logic [CH_W-1:0] ch);
        logic [CH_W-1:0] res;
        begin
            if (ch == '0)
                res = CH_W'(1);
            else if (ch > CH_W'(MAX_CHANNELS))
                res = CH_W'(MAX_CHANNELS);
            else
                res = ch;
            return res;
        end
    endfunction

    function automatic logic [POS_W-1:0] last_index(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] m1;
        logic [POS_W-1:0] res;
        begin
            m1 = len - LEN_W'(1);
            if (len == '0)
                res = '0;
            else if (len > LEN_W'(MAX_LINE))
                res = POS_W'(MAX_LINE - 1);
            else
                res = m1[POS_W-1:0];
            return res;
        end
    endfunction

endpackage

### hw/rtl/bbl_if.sv
// bbl_if: valid/ready request channels for input pixels and filtered results
// depends on nothing

interface bbl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan_a;
    logic [7:0] chan_b;
    logic [7:0] chan_c;
    logic [7:0] chan_d;

    modport source (output valid, output chan_a, output chan_b, output chan_c,
                    output chan_d, input ready);
    modport sink (input valid, input chan_a, input chan_b, input chan_c,
                  input chan_d, output ready);
endinterface

interface bbl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] mean_a;
    logic [7:0] mean_b;
    logic [7:0] mean_c;
    logic [7:0] mean_d;
    logic       run_end;
    logic       line_end;

    modport source (output valid, output mean_a, output mean_b, output mean_c,
                    output mean_d, output run_end, output line_end, input ready);
    modport sink (input valid, input mean_a, input mean_b, input mean_c,
                  input mean_d, input run_end, input line_end, output ready);
endinterface

### hw/rtl/box_blur_line_filter.sv
// box_blur_line_filter: top level with register port, front, request queue and back
// flow: an accepted pixel enters the queue; the back serves one request at a time,
// including each pixel flushed at a line end, and takes no new one before it is done,
// paced by the shared 8-step divider behind the running window sums
// reset: registers return to radius 1, three channels, 640 pixels; line and queue empty
// depends on bbl_pkg, bbl_if, bbl_front, bbl_queue, bbl_div and bbl_back

module box_blur_line_filter (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bbl_pkg::PADDR_W-1:0] paddr,
    input  logic [bbl_pkg::PDATA_W-1:0] pwdata,
    output logic [bbl_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    bbl_in_if.sink                      pix_in,
    bbl_out_if.source                   pix_out
);
    import bbl_pkg::*;

    logic [RAD_W-1:0] radius_reg;
    logic [CH_W-1:0]  channels_reg;
    logic [LEN_W-1:0] length_reg;
    logic             apb_wr;
    logic             cfg_wr;
    logic [1:0]       reg_idx;
    cfg_t             cfg;
    job_t             push_job;
    job_t             pop_job;
    queue_stat_t      q_stat;
    logic             q_push;
    logic             q_pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign apb_wr  = psel && penable && pwrite && pready;
    assign cfg_wr  = apb_wr && (reg_idx == REG_RADIUS || reg_idx == REG_CHANNELS
                                || reg_idx == REG_LENGTH);

    assign cfg.radius   = radius_reg;
    assign cfg.channels = channels_reg;
    assign cfg.length   = length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= RADIUS_RST;
            channels_reg <= CHANNELS_RST;
            length_reg   <= LENGTH_RST;
        end
        else if (apb_wr)
        begin
            unique case (reg_idx)
                REG_RADIUS:   radius_reg   <= pwdata[RAD_W-1:0];
                REG_CHANNELS: channels_reg <= pwdata[CH_W-1:0];
                REG_LENGTH:   length_reg   <= pwdata[LEN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_RADIUS:   prdata = PDATA_W'(radius_reg);
            REG_CHANNELS: prdata = PDATA_W'(channels_reg);
            REG_LENGTH:   prdata = PDATA_W'(length_reg);
            default:      prdata = '0;
        endcase
    end

    bbl_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .cfg_wr (cfg_wr),
        .pix_in (pix_in),
        .q_stat (q_stat),
        .q_push (q_push),
        .q_job  (push_job)
    );

    bbl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .stat     (q_stat)
    );

    bbl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr),
        .q_stat  (q_stat),
        .q_job   (pop_job),
        .q_pop   (q_pop),
        .pix_out (pix_out)
    );

`ifndef ASSERT_OFF
    a_line_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid && pix_out.line_end |-> pix_out.run_end)
        else $error("line end result without run end");

    a_unused_channels_zero: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid && (channels_reg == 3'd0 || channels_reg == 3'd1)
        |-> pix_out.mean_b == 8'd0 && pix_out.mean_c == 8'd0 && pix_out.mean_d == 8'd0)
        else $error("unused channel gives a nonzero mean");

    a_gap_after_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid && pix_out.ready && pix_out.line_end |=> !pix_out.valid)
        else $error("result right after line end");
`endif

endmodule

### hw/rtl/bbl_front.sv
// bbl_front: accepts input pixels, tracks the line position and classifies each request
// depends on bbl_pkg and bbl_in_if; feeds bbl_queue

module bbl_front (
    input  logic                clk,
    input  logic                rst_n,
    input  bbl_pkg::cfg_t       cfg,
    input  logic                cfg_wr,
    bbl_in_if.sink              pix_in,
    input  bbl_pkg::queue_stat_t q_stat,
    output logic                q_push,
    output bbl_pkg::job_t       q_job
);
    import bbl_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [CH_W-1:0]  ch;
    logic [POS_W-1:0] last_idx;
    logic [MAX_CHANNELS-1:0][PIX_W-1:0] chan;

    assign ch       = eff_channels(cfg.channels);
    assign last_idx = last_index(cfg.length);
    assign chan     = {pix_in.chan_d, pix_in.chan_c, pix_in.chan_b, pix_in.chan_a};

    assign pix_in.ready = !q_stat.full;
    assign q_push       = pix_in.valid && pix_in.ready;

    always_comb
    begin
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            q_job.pix[c*PIX_W +: PIX_W] = (CH_W'(c) < ch) ? chan[c] : '0;
        end
        q_job.pos  = pos_reg;
        q_job.drop = pos_reg >= {{(POS_W-RAD_W-1){1'b0}}, cfg.radius, 1'b1};
        q_job.emit = pos_reg >= {{(POS_W-RAD_W){1'b0}}, cfg.radius};
        q_job.last = pos_reg == last_idx;
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (cfg_wr)
            pos_next = '0;
        else if (q_push)
            pos_next = q_job.last ? '0 : pos_reg + POS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

### hw/rtl/bbl_queue.sv
// bbl_queue: short first-in first-out queue of classified requests
// depends on bbl_pkg; sits between bbl_front and bbl_back

module bbl_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  bbl_pkg::job_t        push_job,
    input  logic                 pop,
    output bbl_pkg::job_t        pop_job,
    output bbl_pkg::queue_stat_t stat
);
    import bbl_pkg::*;

    job_t                entries [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;

    assign stat.full  = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;
    assign pop_job    = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            if (push && !pop)
                count_reg <= count_reg + (QUEUE_AW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (QUEUE_AW+1)'(1);
        end
    end

endmodule

### hw/rtl/bbl_div.sv
// bbl_div: restoring divider, one quotient bit per cycle on all channel lanes at once
// depends on bbl_pkg; used by bbl_back

module bbl_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  bbl_pkg::sum_arr_t    dividend,
    input  logic [bbl_pkg::CNT_W-1:0] divisor,
    output logic                 done,
    output bbl_pkg::mean_arr_t   quot
);
    import bbl_pkg::*;

    logic                run_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [CNT_W-1:0]    divisor_reg;
    sum_arr_t            rem_reg;
    sum_arr_t            rem_next;
    mean_arr_t           quot_reg;
    mean_arr_t           quot_next;
    logic [SUM_W-1:0]    trial;

    assign done = done_reg;
    assign quot = quot_reg;

    always_comb
    begin
        trial     = SUM_W'(divisor_reg) << step_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            if (rem_reg[c] >= trial)
            begin
                rem_next[c]            = rem_reg[c] - trial;
                quot_next[c][step_reg] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= dividend;
            quot_reg    <= '0;
            divisor_reg <= divisor;
        end
        else if (run_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= STEP_W'(PIX_W - 1);
            end
            else if (run_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

### hw/rtl/bbl_back.sv
// bbl_back: delay line, running window sums, edge flush sequencer and result register
// depends on bbl_pkg, bbl_out_if and bbl_div; drains bbl_queue

module bbl_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bbl_pkg::cfg_t        cfg,
    input  logic                 cfg_wr,
    input  bbl_pkg::queue_stat_t q_stat,
    input  bbl_pkg::job_t        q_job,
    output logic                 q_pop,
    bbl_out_if.source            pix_out
);
    import bbl_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DROP  = 8'b0000_0010,
        S_PLAN  = 8'b0000_0100,
        S_FPREP = 8'b0000_1000,
        S_FSUB  = 8'b0001_0000,
        S_LOAD  = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [MAX_CHANNELS*PIX_W-1:0] delay_mem [DELAY_DEPTH];
    logic [MAX_CHANNELS*PIX_W-1:0] rd_data_reg;
    logic                          rd_en;
    logic [DELAY_AW-1:0]           rd_addr;
    logic                          wr_en;

    sum_arr_t         sums_reg;
    logic [POS_W-1:0] x_reg;
    logic             last_reg;
    logic             emit_reg;

    logic             out_valid_reg;
    mean_arr_t        means_reg;
    logic             run_end_reg;
    logic             line_end_reg;

    logic [POS_W-1:0] last_idx;
    logic [POS_W-1:0] r_ext;
    logic [POS_W-1:0] drop_pos;
    logic [POS_W-1:0] flush_pos;
    logic             flush_drop;
    logic             at_line_end;
    logic [LEN_W-1:0] lo;
    logic [LEN_W-1:0] hi;
    logic [LEN_W-1:0] x_plus_r;
    logic [LEN_W-1:0] count_w;
    logic             div_start;
    logic             div_done;
    mean_arr_t        div_quot;

    assign last_idx    = last_index(cfg.length);
    assign r_ext       = {{(POS_W-RAD_W){1'b0}}, cfg.radius};
    assign drop_pos    = q_job.pos - {{(POS_W-RAD_W-1){1'b0}}, cfg.radius, 1'b1};
    assign flush_pos   = x_reg - r_ext - POS_W'(1);
    assign flush_drop  = x_reg > r_ext;
    assign at_line_end = x_reg == last_idx;

    assign q_pop = (state_reg == S_IDLE) && !q_stat.empty;
    assign wr_en = q_pop;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = drop_pos[DELAY_AW-1:0];
        if (q_pop && q_job.drop)
            rd_en = 1'b1;
        else if (state_reg == S_FPREP && flush_drop)
        begin
            rd_en   = 1'b1;
            rd_addr = flush_pos[DELAY_AW-1:0];
        end
    end

    // clipped window size for position x_reg
    always_comb
    begin
        x_plus_r = LEN_W'(x_reg) + LEN_W'(cfg.radius);
        lo       = (x_reg > r_ext) ? LEN_W'(x_reg - r_ext) : '0;
        hi       = (x_plus_r < LEN_W'(last_idx)) ? x_plus_r : LEN_W'(last_idx);
        count_w  = hi - lo + LEN_W'(1);
    end

    assign div_start = state_reg == S_LOAD;

    bbl_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sums_reg),
        .divisor  (count_w[CNT_W-1:0]),
        .done     (div_done),
        .quot     (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                    state_next = q_job.drop ? S_DROP : S_PLAN;
            end
            S_DROP:
                state_next = S_PLAN;
            S_PLAN:
            begin
                if (emit_reg)
                    state_next = S_LOAD;
                else if (last_reg)
                    state_next = S_FPREP;
                else
                    state_next = S_IDLE;
            end
            S_FPREP:
                state_next = flush_drop ? S_FSUB : S_LOAD;
            S_FSUB:
                state_next = S_LOAD;
            S_LOAD:
                state_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (pix_out.ready)
                    state_next = (last_reg && !at_line_end) ? S_FPREP : S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            delay_mem[q_job.pos[DELAY_AW-1:0]] <= q_job.pix;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= delay_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            last_reg <= q_job.last;
            emit_reg <= q_job.emit;
            x_reg    <= q_job.emit ? q_job.pos - r_ext : '0;
        end
        else if (state_reg == S_OUT && pix_out.ready && last_reg && !at_line_end)
            x_reg <= x_reg + POS_W'(1);
        if (state_reg == S_DIV && div_done)
        begin
            means_reg    <= div_quot;
            line_end_reg <= at_line_end;
            run_end_reg  <= at_line_end || !last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sums_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
                sums_reg <= '0;
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                    begin
                        if (q_pop)
                            for (int c = 0; c < MAX_CHANNELS; c++)
                                sums_reg[c] <= sums_reg[c]
                                    + SUM_W'(q_job.pix[c*PIX_W +: PIX_W]);
                    end
                    S_DROP, S_FSUB:
                    begin
                        for (int c = 0; c < MAX_CHANNELS; c++)
                            sums_reg[c] <= sums_reg[c]
                                - SUM_W'(rd_data_reg[c*PIX_W +: PIX_W]);
                    end
                    S_OUT:
                    begin
                        if (pix_out.ready && line_end_reg)
                            sums_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == S_DIV && div_done)
                out_valid_reg <= 1'b1;
            else if (state_reg == S_OUT && pix_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign pix_out.valid    = out_valid_reg;
    assign pix_out.mean_a   = means_reg[0];
    assign pix_out.mean_b   = means_reg[1];
    assign pix_out.mean_c   = means_reg[2];
    assign pix_out.mean_d   = means_reg[3];
    assign pix_out.run_end  = run_end_reg;
    assign pix_out.line_end = line_end_reg;

endmodule
